### rtl/dlts_pkg.sv
// Package: shared constants, types and codes of the delta-list task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package dlts_pkg;

    localparam int MAX_TASKS   = 16;
    localparam int READY_DEPTH = 16;
    localparam int TIME_WIDTH  = 32;

    localparam int PTR_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int RCNT_W = $clog2(READY_DEPTH + 1);

    typedef logic [TIME_WIDTH-1:0] tval_t;

    typedef struct packed {
        logic [7:0] handle;
        tval_t      delta;
        tval_t      period;
        logic [7:0] pending;
        logic [7:0] ident;
    } entry_t;

    typedef struct packed {
        logic [7:0] ident;
        logic [7:0] handle;
    } ready_item_t;

    // Commands broadcast to the cell row
    localparam logic [1:0] CELL_NOP        = 2'd0;
    localparam logic [1:0] CELL_TICK       = 2'd1;
    localparam logic [1:0] CELL_SHIFT_UP   = 2'd2;
    localparam logic [1:0] CELL_SHIFT_DOWN = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [PTR_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic             found;
        tval_t            succ_delta;
        entry_t           new_entry;
    } cell_cmd_t;

    // Item operations
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;
    localparam logic [1:0] OP_DELETE   = 2'd3;

    // Sticky error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_FULL   = 2'd1;
    localparam logic [1:0] ERR_DELETE = 2'd2;

endpackage
`default_nettype wire

### rtl/dlts_ifs.sv
// Interfaces: request and response channels of the delta-list task scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface dlts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  task_handle;
    logic [31:0] start_delay;
    logic [31:0] repeat_period;
    logic [3:0]  list_position;

    modport source (output valid, operation, task_handle, start_delay, repeat_period,
                    list_position, input ready);
    modport sink (input valid, operation, task_handle, start_delay, repeat_period,
                  list_position, output ready);
endinterface

interface dlts_out_if;
    logic       valid;
    logic       ready;
    logic       run_valid;
    logic [7:0] run_handle;
    logic [7:0] run_task_id;
    logic [4:0] add_position;
    logic       delete_ok;
    logic [1:0] error_code;
    logic [4:0] task_count;

    modport source (output valid, run_valid, run_handle, run_task_id, add_position,
                    delete_ok, error_code, task_count, input ready);
    modport sink (input valid, run_valid, run_handle, run_task_id, add_position,
                  delete_ok, error_code, task_count, output ready);
endinterface
`default_nettype wire

### rtl/dlts_cell.sv
// List cell: holds one timed entry and shifts to or from its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module dlts_cell
    import dlts_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_cmd_t        cmd,
    input  wire logic [PTR_W-1:0] idx,
    input  wire entry_t           left,
    input  wire entry_t           right,
    output entry_t                ent
);

    entry_t              ent_reg;
    entry_t              ent_next;
    logic [TIME_WIDTH:0] fold_sum;

    always_comb
    begin
        ent_next = ent_reg;
        fold_sum = {1'b0, ent_reg.delta} + {1'b0, right.delta};
        unique case (cmd.op)
            CELL_TICK:
            begin
                if (idx == '0)
                begin
                    if (ent_reg.delta != '0)
                        ent_next.delta = ent_reg.delta - 1'b1;
                    if (ent_next.delta == '0 && ent_reg.pending != 8'hFF)
                        ent_next.pending = ent_reg.pending + 8'd1;
                end
            end
            CELL_SHIFT_UP:
            begin
                if (idx == cmd.pos)
                    ent_next = cmd.new_entry;
                else if (idx > cmd.pos)
                begin
                    ent_next = left;
                    if (cmd.found && CNT_W'(idx) == CNT_W'(cmd.pos) + CNT_W'(1))
                        ent_next.delta = cmd.succ_delta;
                end
            end
            CELL_SHIFT_DOWN:
            begin
                if (idx >= cmd.pos)
                begin
                    ent_next = right;
                    // removed delta folds into the successor, saturating
                    if (idx == cmd.pos && CNT_W'(idx) + CNT_W'(1) < cmd.count)
                        ent_next.delta = fold_sum[TIME_WIDTH] ? '1 : fold_sum[TIME_WIDTH-1:0];
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= '0;
        else
            ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule
`default_nettype wire

### rtl/dlts_ready.sv
// Ready queue: shift row of dispatched tasks, pushed at the tail, popped at the head.
`timescale 1ns / 1ps
`default_nettype none
module dlts_ready
    import dlts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ready_item_t       push_data,
    input  wire logic              pop,
    output ready_item_t            head,
    output logic [RCNT_W-1:0]      count,
    output logic                   full
);

    ready_item_t         slot_reg  [READY_DEPTH];
    ready_item_t         slot_next [READY_DEPTH];
    logic [RCNT_W-1:0]   count_reg;
    logic [RCNT_W-1:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        for (int k = 0; k < READY_DEPTH; k++)
        begin
            slot_next[k] = slot_reg[k];
            if (push && RCNT_W'(k) == count_reg)
                slot_next[k] = push_data;
            if (pop)
                slot_next[k] = (k + 1 < READY_DEPTH) ? slot_reg[(k + 1) % READY_DEPTH] : '0;
        end
        if (push)
            count_next = count_reg + RCNT_W'(1);
        else if (pop)
            count_next = count_reg - RCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int k = 0; k < READY_DEPTH; k++)
                slot_reg[k] <= '0;
        end
        else
        begin
            count_reg <= count_next;
            for (int k = 0; k < READY_DEPTH; k++)
                slot_reg[k] <= slot_next[k];
        end
    end

    assign head  = slot_reg[0];
    assign count = count_reg;
    assign full  = (count_reg == RCNT_W'(READY_DEPTH));

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n) !(push && pop))
        else $error("ready queue push and pop together");
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("ready queue push while full");
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> count_reg == $past(count_reg) - RCNT_W'(1))
        else $error("ready queue pop miscounted");

endmodule
`default_nettype wire

### rtl/delta_list_task_scheduler.sv
// Top level: delta-list task scheduler, a row of list cells, a ready queue and the sequencer.
// One item is taken at a time. Tick and delete go from decode straight to the result;
// add walks the list, one cumulative delta per cycle, to find the insert position, and a
// dispatch of a periodic task removes the head, walks the list again and pops the ready
// queue. The cell row shifts all entries together on one command. A new item is taken
// once the previous result sits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module delta_list_task_scheduler
    import dlts_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dlts_in_if.sink    req,
    dlts_out_if.source rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_POP    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [7:0]       handle_reg, handle_next;
    tval_t            delay_reg, delay_next;
    tval_t            period_reg, period_next;
    logic [3:0]       pos_reg, pos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       cid_reg, cid_next;
    logic [7:0]       cpend_reg, cpend_next;
    logic [1:0]       err_reg, err_next;
    logic [CNT_W-1:0] walk_idx_reg, walk_idx_next;
    tval_t            cum_reg, cum_next;
    logic [PTR_W-1:0] ins_pos_reg, ins_pos_next;
    tval_t            ins_delta_reg, ins_delta_next;
    tval_t            succ_reg, succ_next;
    logic             found_reg, found_next;

    logic             run_valid_reg, run_valid_next;
    logic [7:0]       run_handle_reg, run_handle_next;
    logic [7:0]       run_id_reg, run_id_next;
    logic [CNT_W-1:0] add_pos_reg, add_pos_next;
    logic             del_ok_reg, del_ok_next;

    logic             rsp_valid_reg, rsp_valid_next;
    logic             o_run_valid_reg;
    logic [7:0]       o_run_handle_reg;
    logic [7:0]       o_run_id_reg;
    logic [4:0]       o_add_pos_reg;
    logic             o_del_ok_reg;
    logic [1:0]       o_err_reg;
    logic [4:0]       o_count_reg;

    cell_cmd_t         cmd;
    entry_t            ent_q [MAX_TASKS];
    entry_t            walk_ent;
    entry_t            del_ent;
    entry_t            head_ent;
    logic [TIME_WIDTH:0] walk_sum;
    logic              fifo_push, fifo_pop, fifo_full;
    ready_item_t       fifo_data, fifo_head;
    logic [RCNT_W-1:0] fifo_count;
    logic              accept, load_out, due;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            dlts_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .idx   (PTR_W'(gi)),
                .left  ((gi == 0) ? entry_t'('0) : ent_q[(gi + MAX_TASKS - 1) % MAX_TASKS]),
                .right ((gi == MAX_TASKS - 1) ? entry_t'('0) : ent_q[(gi + 1) % MAX_TASKS]),
                .ent   (ent_q[gi])
            );
        end
    endgenerate

    dlts_ready u_ready (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_data),
        .pop       (fifo_pop),
        .head      (fifo_head),
        .count     (fifo_count),
        .full      (fifo_full)
    );

    assign head_ent = ent_q[0];
    assign walk_ent = ent_q[walk_idx_reg[PTR_W-1:0]];
    assign del_ent  = ent_q[PTR_W'(pos_reg)];
    assign walk_sum = {1'b0, cum_reg} + {1'b0, walk_ent.delta};
    assign due      = (count_reg != '0) && (head_ent.delta == '0) && (head_ent.pending != 8'd0);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign load_out  = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        handle_next     = handle_reg;
        delay_next      = delay_reg;
        period_next     = period_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        cid_next        = cid_reg;
        cpend_next      = cpend_reg;
        err_next        = err_reg;
        walk_idx_next   = walk_idx_reg;
        cum_next        = cum_reg;
        ins_pos_next    = ins_pos_reg;
        ins_delta_next  = ins_delta_reg;
        succ_next       = succ_reg;
        found_next      = found_reg;
        run_valid_next  = run_valid_reg;
        run_handle_next = run_handle_reg;
        run_id_next     = run_id_reg;
        add_pos_next    = add_pos_reg;
        del_ok_next     = del_ok_reg;
        cmd             = '0;
        cmd.op          = CELL_NOP;
        cmd.count       = count_reg;
        fifo_push       = 1'b0;
        fifo_pop        = 1'b0;
        fifo_data       = '{ident: head_ent.ident, handle: head_ent.handle};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req.operation;
                    handle_next     = req.task_handle;
                    delay_next      = req.start_delay[TIME_WIDTH-1:0];
                    period_next     = req.repeat_period[TIME_WIDTH-1:0];
                    pos_next        = req.list_position;
                    run_valid_next  = 1'b0;
                    run_handle_next = '0;
                    run_id_next     = '0;
                    add_pos_next    = '0;
                    del_ok_next     = 1'b0;
                    walk_idx_next   = '0;
                    cum_next        = '0;
                    state_next      = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (op_reg)
                    OP_TICK:
                    begin
                        if (count_reg != '0)
                            cmd.op = CELL_TICK;
                        state_next = S_FINISH;
                    end
                    OP_ADD:
                    begin
                        if (count_reg >= CNT_W'(MAX_TASKS))
                        begin
                            err_next     = ERR_FULL;
                            add_pos_next = CNT_W'(MAX_TASKS);
                            state_next   = S_FINISH;
                        end
                        else
                            state_next = S_WALK;
                    end
                    OP_DISPATCH:
                    begin
                        if (due)
                        begin
                            fifo_push   = !fifo_full;
                            handle_next = head_ent.handle;
                            delay_next  = head_ent.period;
                            period_next = head_ent.period;
                            cmd.op      = CELL_SHIFT_DOWN;
                            cmd.pos     = '0;
                            count_next  = count_reg - CNT_W'(1);
                            if (head_ent.period != '0)
                            begin
                                cpend_next = head_ent.pending - 8'd1;
                                cid_next   = head_ent.ident;
                                state_next = S_WALK;
                            end
                            else
                                state_next = S_POP;
                        end
                        else
                            state_next = S_POP;
                    end
                    OP_DELETE:
                    begin
                        if (CNT_W'(pos_reg) >= count_reg)
                            err_next = ERR_DELETE;
                        else
                        begin
                            if (del_ent.period != '0)
                                cid_next = del_ent.ident;
                            cmd.op      = CELL_SHIFT_DOWN;
                            cmd.pos     = PTR_W'(pos_reg);
                            count_next  = count_reg - CNT_W'(1);
                            del_ok_next = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_WALK:
            begin
                if (walk_idx_reg < count_reg)
                begin
                    if (walk_sum > {1'b0, delay_reg})
                    begin
                        found_next     = 1'b1;
                        ins_pos_next   = walk_idx_reg[PTR_W-1:0];
                        ins_delta_next = delay_reg - cum_reg;
                        succ_next      = walk_sum[TIME_WIDTH-1:0] - delay_reg;
                        state_next     = S_INSERT;
                    end
                    else
                    begin
                        walk_idx_next = walk_idx_reg + CNT_W'(1);
                        cum_next      = walk_sum[TIME_WIDTH-1:0];
                    end
                end
                else
                begin
                    found_next     = 1'b0;
                    ins_pos_next   = walk_idx_reg[PTR_W-1:0];
                    ins_delta_next = delay_reg - cum_reg;
                    state_next     = S_INSERT;
                end
            end
            S_INSERT:
            begin
                cmd.op                = CELL_SHIFT_UP;
                cmd.pos               = ins_pos_reg;
                cmd.found             = found_reg;
                cmd.succ_delta        = succ_reg;
                cmd.new_entry.handle  = handle_reg;
                cmd.new_entry.delta   = ins_delta_reg;
                cmd.new_entry.period  = period_reg;
                cmd.new_entry.pending = cpend_reg;
                cmd.new_entry.ident   = (cid_reg != 8'd0) ? cid_reg
                                                          : 8'(count_reg + CNT_W'(1));
                count_next = count_reg + CNT_W'(1);
                cid_next   = '0;
                cpend_next = '0;
                if (op_reg == OP_ADD)
                begin
                    add_pos_next = CNT_W'(ins_pos_reg);
                    state_next   = S_FINISH;
                end
                else
                    state_next = S_POP;
            end
            S_POP:
            begin
                if (fifo_count != '0)
                begin
                    fifo_pop        = 1'b1;
                    run_valid_next  = 1'b1;
                    run_handle_next = fifo_head.handle;
                    run_id_next     = fifo_head.ident;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;
        if (load_out)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cid_reg       <= '0;
            cpend_reg     <= '0;
            err_reg       <= ERR_NONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cid_reg       <= cid_next;
            cpend_reg     <= cpend_next;
            err_reg       <= err_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        handle_reg     <= handle_next;
        delay_reg      <= delay_next;
        period_reg     <= period_next;
        pos_reg        <= pos_next;
        walk_idx_reg   <= walk_idx_next;
        cum_reg        <= cum_next;
        ins_pos_reg    <= ins_pos_next;
        ins_delta_reg  <= ins_delta_next;
        succ_reg       <= succ_next;
        found_reg      <= found_next;
        run_valid_reg  <= run_valid_next;
        run_handle_reg <= run_handle_next;
        run_id_reg     <= run_id_next;
        add_pos_reg    <= add_pos_next;
        del_ok_reg     <= del_ok_next;
        if (load_out)
        begin
            o_run_valid_reg  <= run_valid_reg;
            o_run_handle_reg <= run_handle_reg;
            o_run_id_reg     <= run_id_reg;
            o_add_pos_reg    <= 5'(add_pos_reg);
            o_del_ok_reg     <= del_ok_reg;
            o_err_reg        <= err_reg;
            o_count_reg      <= 5'(count_reg);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.run_valid    = o_run_valid_reg;
    assign rsp.run_handle   = o_run_handle_reg;
    assign rsp.run_task_id  = o_run_id_reg;
    assign rsp.add_position = o_add_pos_reg;
    assign rsp.delete_ok    = o_del_ok_reg;
    assign rsp.error_code   = o_err_reg;
    assign rsp.task_count   = o_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count above list size");
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INSERT) |-> (count_reg < CNT_W'(MAX_TASKS)))
        else $error("insert into full list");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (walk_idx_reg <= count_reg))
        else $error("walk past end of list");
    a_finish_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && rsp_valid_reg && !rsp.ready) |=> (state_reg == S_FINISH))
        else $error("result dropped while output stalled");

endmodule
`default_nettype wire

### dv/tb_top.sv
// Testbench: drives scheduler operations and checks every result against a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top
    import dlts_pkg::*;
;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  task_handle;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
        logic [3:0]  list_position;
    } sched_op_t;

    typedef struct packed {
        logic       run_valid;
        logic [7:0] run_handle;
        logic [7:0] run_task_id;
        logic [4:0] add_position;
        logic       delete_ok;
        logic [1:0] error_code;
        logic [4:0] task_count;
    } sched_res_t;

    logic clk;
    logic rst_n;

    dlts_in_if  req ();
    dlts_out_if rsp ();

    delta_list_task_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // predictor state
    logic [7:0]  m_handle [MAX_TASKS];
    logic [31:0] m_delta [MAX_TASKS];
    logic [31:0] m_period [MAX_TASKS];
    logic [7:0]  m_pending [MAX_TASKS];
    logic [7:0]  m_ident [MAX_TASKS];
    int          m_count;
    logic [15:0] m_ready [$];
    logic [7:0]  m_carry_id;
    logic [7:0]  m_carry_pend;
    logic [1:0]  m_err;

    sched_op_t  op_queue [$];
    sched_res_t expected_results [$];
    int         errors;
    int         results_seen;
    int         runs_seen;
    bit         idle_off;
    bit         hold_rx;
    int         tx_gap;
    int         rx_gap;
    bit         stim_done;
    bit         in_fire;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    function automatic void list_reset();
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            m_handle[i] = '0;
            m_delta[i] = '0;
            m_period[i] = '0;
            m_pending[i] = '0;
            m_ident[i] = '0;
        end
        m_count = 0;
        m_ready.delete();
        m_carry_id = '0;
        m_carry_pend = '0;
        m_err = ERR_NONE;
    endfunction

    function automatic bit list_remove(input int pos);
        logic [32:0] sum;
        if (pos >= m_count)
        begin
            m_err = ERR_DELETE;
            return 1'b0;
        end
        if (m_period[pos] != 0)
            m_carry_id = m_ident[pos];
        if (pos + 1 < m_count)
        begin
            sum = {1'b0, m_delta[pos + 1]} + {1'b0, m_delta[pos]};
            m_delta[pos + 1] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        for (int i = pos; i + 1 < m_count; i++)
        begin
            m_handle[i] = m_handle[i + 1];
            m_delta[i] = m_delta[i + 1];
            m_period[i] = m_period[i + 1];
            m_pending[i] = m_pending[i + 1];
            m_ident[i] = m_ident[i + 1];
        end
        m_handle[m_count - 1] = '0;
        m_delta[m_count - 1] = '0;
        m_period[m_count - 1] = '0;
        m_pending[m_count - 1] = '0;
        m_ident[m_count - 1] = '0;
        m_count--;
        return 1'b1;
    endfunction

    function automatic int list_insert(input logic [7:0] h, input logic [31:0] d,
                                       input logic [31:0] p);
        int idx;
        logic [36:0] cum;
        logic [36:0] prev;
        bit found;
        idx = 0;
        cum = '0;
        prev = '0;
        found = 1'b0;
        if (m_count >= MAX_TASKS)
        begin
            m_err = ERR_FULL;
            return MAX_TASKS;
        end
        while (idx < m_count)
        begin
            prev = cum;
            cum += m_delta[idx];
            if (cum > d)
            begin
                found = 1'b1;
                break;
            end
            idx++;
        end
        m_count++;
        if (found)
        begin
            for (int i = m_count - 1; i > idx; i--)
            begin
                m_handle[i] = m_handle[i - 1];
                m_delta[i] = m_delta[i - 1];
                m_period[i] = m_period[i - 1];
                m_pending[i] = m_pending[i - 1];
                m_ident[i] = m_ident[i - 1];
            end
            m_delta[idx] = d - prev[31:0];
            m_delta[idx + 1] = m_delta[idx + 1] - m_delta[idx];
        end
        else
            m_delta[idx] = d - cum[31:0];
        m_handle[idx] = h;
        m_period[idx] = p;
        m_pending[idx] = m_carry_pend;
        m_ident[idx] = (m_carry_id != 0) ? m_carry_id : 8'(m_count);
        m_carry_pend = '0;
        m_carry_id = '0;
        return idx;
    endfunction

    function automatic sched_res_t predict_schedule(input sched_op_t o);
        sched_res_t r;
        logic [7:0] h;
        logic [31:0] p;
        bit ok;
        int pos;
        r = '0;
        case (o.operation)
            OP_TICK:
                if (m_count > 0)
                begin
                    if (m_delta[0] > 0)
                        m_delta[0]--;
                    if (m_delta[0] == 0 && m_pending[0] != 8'hFF)
                        m_pending[0]++;
                end
            OP_ADD:
                r.add_position = 5'(list_insert(o.task_handle, o.start_delay,
                                                o.repeat_period));
            OP_DISPATCH:
            begin
                if (m_count > 0 && m_delta[0] == 0 && m_pending[0] > 0)
                begin
                    h = m_handle[0];
                    p = m_period[0];
                    if (m_ready.size() < READY_DEPTH)
                        m_ready.push_back({m_ident[0], h});
                    m_pending[0]--;
                    if (p > 0)
                    begin
                        m_carry_pend = m_pending[0];
                        ok = list_remove(0);
                        pos = list_insert(h, p, p);
                    end
                    else
                        ok = list_remove(0);
                end
                if (m_ready.size() > 0)
                begin
                    r.run_valid = 1'b1;
                    r.run_handle = m_ready[0][7:0];
                    r.run_task_id = m_ready[0][15:8];
                    void'(m_ready.pop_front());
                end
            end
            default:
                r.delete_ok = list_remove(int'(o.list_position));
        endcase
        r.error_code = m_err;
        r.task_count = 5'(m_count);
        return r;
    endfunction

    function automatic sched_op_t make_op(input logic [1:0] op, input logic [7:0] h,
                                          input logic [31:0] d, input logic [31:0] p,
                                          input logic [3:0] pos);
        sched_op_t o;
        o.operation = op;
        o.task_handle = h;
        o.start_delay = d;
        o.repeat_period = p;
        o.list_position = pos;
        return o;
    endfunction

    function automatic logic [31:0] rand_delay();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2, 3: return '0;
            default: return $urandom_range(0, 6);
        endcase
    endfunction

    function automatic sched_op_t rand_op();
        int k;
        logic [7:0] h;
        k = $urandom_range(0, 99);
        h = 8'($urandom_range(0, 255));
        if (k < 35)
            return make_op(OP_TICK, h, $urandom(), $urandom(), 4'($urandom()));
        if (k < 60)
            return make_op(OP_ADD, h, rand_delay(), ($urandom_range(0, 2) == 0) ? '0 :
                           rand_delay(), 4'($urandom()));
        if (k < 85)
            return make_op(OP_DISPATCH, h, $urandom(), $urandom(), 4'($urandom()));
        return make_op(OP_DELETE, h, $urandom(), $urandom(),
                       4'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 15 : 4)));
    endfunction

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.operation <= OP_TICK;
            req.task_handle <= '0;
            req.start_delay <= '0;
            req.repeat_period <= '0;
            req.list_position <= '0;
            tx_gap <= 0;
        end
        else if (!(req.valid && !in_fire))
        begin
            if (tx_gap > 0)
            begin
                req.valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (!idle_off && $urandom_range(0, 7) == 0)
            begin
                req.valid <= 1'b0;
                tx_gap <= $urandom_range(0, 3);
            end
            else if (op_queue.size() > 0)
            begin
                req.valid <= 1'b1;
                {req.operation, req.task_handle, req.start_delay, req.repeat_period,
                 req.list_position} <= op_queue.pop_front();
            end
            else
                req.valid <= 1'b0;
        end
    end

    // accept and predict
    always @(posedge clk)
    begin
        in_fire <= rst_n && req.valid && req.ready;
        if (rst_n && req.valid && req.ready)
            expected_results.push_back(predict_schedule({req.operation, req.task_handle,
                req.start_delay, req.repeat_period, req.list_position}));
    end

    // receiver stall
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rx_gap <= 0;
        end
        else if (hold_rx)
            rsp.ready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rsp.ready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end
        else if (!idle_off && $urandom_range(0, 7) == 0)
        begin
            rsp.ready <= 1'b0;
            rx_gap <= $urandom_range(0, 3);
        end
        else
            rsp.ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        sched_res_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report("unexpected result", results_seen, 0);
            else
            begin
                want = expected_results.pop_front();
                if (rsp.run_valid) runs_seen++;
                if (rsp.run_valid !== want.run_valid)
                    report("run_valid", rsp.run_valid, want.run_valid);
                if (rsp.run_handle !== want.run_handle)
                    report("run_handle", rsp.run_handle, want.run_handle);
                if (rsp.run_task_id !== want.run_task_id)
                    report("run_task_id", rsp.run_task_id, want.run_task_id);
                if (rsp.add_position !== want.add_position)
                    report("add_position", rsp.add_position, want.add_position);
                if (rsp.delete_ok !== want.delete_ok)
                    report("delete_ok", rsp.delete_ok, want.delete_ok);
                if (rsp.error_code !== want.error_code)
                    report("error_code", rsp.error_code, want.error_code);
                if (rsp.task_count !== want.task_count)
                    report("task_count", rsp.task_count, want.task_count);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        sched_op_t o;
        int guard;
        errors = 0;
        results_seen = 0;
        runs_seen = 0;
        idle_off = 1'b0;
        hold_rx = 1'b0;
        stim_done = 1'b0;
        in_fire = 1'b0;
        list_reset();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty-list cases, extremes, fold, saturation, fill to full
        op_queue.push_back(make_op(OP_TICK, 8'h00, '0, '0, 4'h0));
        op_queue.push_back(make_op(OP_DISPATCH, 8'h00, '0, '0, 4'h0));
        op_queue.push_back(make_op(OP_DELETE, 8'hFF, '1, '1, 4'hF));
        op_queue.push_back(make_op(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
        op_queue.push_back(make_op(OP_ADD, 8'h01, 32'hFFFF_FFFE, 32'h0, 4'h0));
        op_queue.push_back(make_op(OP_ADD, 8'hA5, 32'h0, 32'h2, 4'h0));
        op_queue.push_back(make_op(OP_DELETE, 8'h00, '0, '0, 4'h1));
        op_queue.push_back(make_op(OP_TICK, 8'h00, '0, '0, 4'h0));
        op_queue.push_back(make_op(OP_DISPATCH, 8'h00, '0, '0, 4'h0));
        op_queue.push_back(make_op(OP_DISPATCH, 8'h00, '0, '0, 4'h0));
        op_queue.push_back(make_op(OP_TICK, 8'h00, '0, '0, 4'h0));
        op_queue.push_back(make_op(OP_TICK, 8'h00, '0, '0, 4'h0));
        op_queue.push_back(make_op(OP_TICK, 8'h00, '0, '0, 4'h0));
        op_queue.push_back(make_op(OP_DISPATCH, 8'h00, '0, '0, 4'h0));
        for (int i = 0; i < 16; i++)
            op_queue.push_back(make_op(OP_ADD, 8'(i + 16), 32'(i % 5), 32'(i % 3), 4'h0));
        for (int i = 0; i < 300; i++)
            op_queue.push_back(make_op(OP_TICK, 8'h00, '0, '0, 4'h0));
        for (int i = 0; i < 20; i++)
            op_queue.push_back(make_op(OP_DISPATCH, 8'h00, '0, '0, 4'h0));

        // long receiver hold while items keep coming
        for (int i = 0; i < 40; i++)
            op_queue.push_back(rand_op());
        wait (op_queue.size() < 30);
        hold_rx = 1'b1;
        for (int c = 0; c < 200; c++)
            @(posedge clk);
        hold_rx = 1'b0;

        for (int i = 0; i < 900; i++)
        begin
            o = rand_op();
            if (i > 780) idle_off = 1'b1;
            op_queue.push_back(o);
            while (op_queue.size() > 8)
                @(posedge clk);
        end
        wait (op_queue.size() == 0);
        @(posedge clk);
        while (req.valid)
            @(posedge clk);
        guard = 0;
        while (expected_results.size() > 0 && guard < 100_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (MAX_TASKS + 10) @(posedge clk);
        $display("Covered tick, add, dispatch and delete incl. full list, bad delete, folds;");
        $display("%0d results checked, %0d tasks handed out", results_seen, runs_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
rtl/dlts_pkg.sv
rtl/dlts_ifs.sv
rtl/dlts_cell.sv
rtl/dlts_ready.sv
rtl/delta_list_task_scheduler.sv
dv/tb_top.sv
